/* hw/rtl/extent_translation_cache_top_defines.svh */
// ----------------------------------------------------------------------------
// Extent translation cache assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef EXTENT_TRANSLATION_CACHE_TOP_DEFINES_SVH
`define EXTENT_TRANSLATION_CACHE_TOP_DEFINES_SVH

// Same-cycle implication
`define ETC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ETC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/etc_pkg.sv */
// ----------------------------------------------------------------------------
// Extent translation cache package
// Shared types, codes and default sizes.
// ----------------------------------------------------------------------------
package etc_pkg;

  localparam int unsigned ENTRIES_DEF     = 16;
  localparam int unsigned SECTOR_BITS_DEF = 48;
  localparam int unsigned FIELD_W         = 48;
  localparam int unsigned REMOVED_W       = 5;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_TRIM   = 2'd2,
    FN_CLEAR  = 2'd3
  } etc_func_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_COVERED  = 2'd1,
    STS_CONFLICT = 2'd2,
    STS_FULL     = 2'd3
  } etc_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_A,
    ST_CHECK,
    ST_SCAN_B,
    ST_MERGE,
    ST_WRITE,
    ST_LOOKUP,
    ST_DROP
  } etc_state_e;

  // Compare results for the entry at the head of the ring
  typedef struct packed {
    logic overlap;   // intersects the request range
    logic covers;    // contains the whole request range
    logic off_diff;  // logical-to-physical offset differs
    logic prv_adj;   // runs on into the merged start
    logic nxt_adj;   // continues the merged end
    logic end_gt_s;  // ends after the request start
  } etc_flags_t;

endpackage

/* hw/rtl/etc_cell.sv */
// ----------------------------------------------------------------------------
// Extent ring cell
// Holds one extent and passes it to the next cell on every shift.
// ----------------------------------------------------------------------------
module etc_cell #(
  parameter int unsigned SW = etc_pkg::SECTOR_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          valid_i,
  input  logic [SW-1:0] start_i,
  input  logic [SW-1:0] end_i,
  input  logic [SW-1:0] phys_i,
  output logic          valid_o,
  output logic [SW-1:0] start_o,
  output logic [SW-1:0] end_o,
  output logic [SW-1:0] phys_o
);

  logic          valid_q;
  logic [SW-1:0] start_q, end_q, phys_q;

  // valid bit, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  // extent payload
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      start_q <= start_i;
      end_q   <= end_i;
      phys_q  <= phys_i;
    end
  end

  assign valid_o = valid_q;
  assign start_o = start_q;
  assign end_o   = end_q;
  assign phys_o  = phys_q;

endmodule

/* hw/rtl/etc_eval.sv */
// ----------------------------------------------------------------------------
// Extent head evaluator
// Compares the extent at the ring head against the request and merge range.
// ----------------------------------------------------------------------------
module etc_eval #(
  parameter int unsigned SW = etc_pkg::SECTOR_BITS_DEF
) (
  input  logic               valid_i,
  input  logic [SW-1:0]      start_i,
  input  logic [SW-1:0]      end_i,
  input  logic [SW-1:0]      phys_i,
  input  logic [SW-1:0]      req_s_i,
  input  logic [SW-1:0]      req_e_i,
  input  logic [SW-1:0]      req_off_i,
  input  logic [SW-1:0]      ns_i,
  input  logic [SW-1:0]      ne_i,
  input  logic [SW-1:0]      np_i,
  output etc_pkg::etc_flags_t flags_o
);

  logic          ov;
  logic [SW-1:0] h_off, h_pend, n_pend;

  assign h_off  = phys_i - start_i;
  assign h_pend = phys_i + (end_i - start_i);
  assign n_pend = np_i + (ne_i - ns_i);
  assign ov     = valid_i && (start_i < req_e_i) && (end_i > req_s_i);

  // flag set for this entry
  always_comb begin
    flags_o.overlap  = ov;
    flags_o.covers   = valid_i && (start_i <= req_s_i) && (end_i >= req_e_i);
    flags_o.off_diff = (h_off != req_off_i);
    flags_o.prv_adj  = valid_i && !ov && (ns_i != '0) && (end_i == ns_i) &&
                       (h_pend == np_i);
    flags_o.nxt_adj  = valid_i && !ov && (start_i == ne_i) && (phys_i == n_pend);
    flags_o.end_gt_s = valid_i && (end_i > req_s_i);
  end

endmodule

/* hw/rtl/extent_translation_cache_top.sv */
// ----------------------------------------------------------------------------
// Extent translation cache
// Table of disjoint logical-to-physical extents held in a rotating ring.
// ----------------------------------------------------------------------------
// The extents sit in a ring of ENTRIES cells that rotates one place per cycle
// while a turn runs; each operation is judged at the ring head. Lookup, trim
// and clear make one full turn; insert makes a scan for overlaps, a scan for
// neighbors and a write-back turn, and stops early when refused after either
// scan, or at once when its start sector is all ones. One item is worked at a
// time; the result sits in an output register, so the next item is taken
// while it waits.
module extent_translation_cache_top #(
  parameter int unsigned ENTRIES     = etc_pkg::ENTRIES_DEF,
  parameter int unsigned SECTOR_BITS = etc_pkg::SECTOR_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_sector[47:0], length[95:48], phys_sector[143:96]
  input  logic [143:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ext_start[47:0], ext_end[95:48], ext_phys[143:96], removed[148:144]
  output logic [151:0] m_axis_tdata,
  // status[1:0], hit[2]
  output logic [2:0]   m_axis_tuser
);

  `include "extent_translation_cache_top_defines.svh"

  localparam int unsigned SW = SECTOR_BITS;
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned FW = etc_pkg::FIELD_W;
  localparam int unsigned RW = etc_pkg::REMOVED_W;

  // ring
  logic          c_valid [ENTRIES];
  logic [SW-1:0] c_start [ENTRIES];
  logic [SW-1:0] c_end   [ENTRIES];
  logic [SW-1:0] c_phys  [ENTRIES];
  logic          t_valid;
  logic [SW-1:0] t_start, t_end, t_phys;
  logic          shift;

  logic          hv;
  logic [SW-1:0] hs, he, hp;
  etc_pkg::etc_flags_t fl;

  etc_pkg::etc_state_e state_q, state_d;
  logic [IW-1:0] k_q, k_d;
  logic          k_last;

  // request and merge registers
  etc_pkg::etc_func_e func_q, func_d;
  logic [SW-1:0] s_q, s_d, e_q, e_d, off_q, off_d;
  logic [SW-1:0] ns_q, ns_d, ne_q, ne_d, np_q, np_d;
  logic          sel_f_q, sel_f_d, cov_f_q, cov_f_d;
  logic [SW-1:0] sel_s_q, sel_s_d, sel_e_q, sel_e_d, sel_p_q, sel_p_d;
  logic [SW-1:0] cov_s_q, cov_s_d, cov_e_q, cov_e_d, cov_p_q, cov_p_d;
  logic          kill_f_q, kill_f_d, free_f_q, free_f_d, wr_q, wr_d;
  logic          prv_f_q, prv_f_d, nxt_f_q, nxt_f_d;
  logic [IW-1:0] prv_i_q, prv_i_d, nxt_i_q, nxt_i_d;
  logic [SW-1:0] prv_s_q, prv_s_d, prv_p_q, prv_p_d, nxt_e_q, nxt_e_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // result and output registers
  logic          res_v_q, res_v_d;
  etc_pkg::etc_status_e res_st_q, res_st_d;
  logic          res_hit_q, res_hit_d;
  logic [SW-1:0] res_s_q, res_s_d, res_e_q, res_e_d, res_p_q, res_p_d;
  logic [RW-1:0] res_rm_q, res_rm_d;
  logic          mv_q, mv_d;
  logic [151:0]  md_q, md_d;
  logic [2:0]    mu_q, mu_d;

  logic          in_xfer, out_free, drop, len_zero;
  logic [SW-1:0] in_s, in_len, in_p, len_eff;
  logic [SW:0]   sum;

  // ring of cells, head at the highest index
  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    if (j == 0) begin : g_tail
      etc_cell #(.SW(SW)) u_cell (
        .clk_i, .rst_ni, .shift_i(shift),
        .valid_i(t_valid), .start_i(t_start), .end_i(t_end), .phys_i(t_phys),
        .valid_o(c_valid[j]), .start_o(c_start[j]), .end_o(c_end[j]),
        .phys_o(c_phys[j])
      );
    end else begin : g_body
      etc_cell #(.SW(SW)) u_cell (
        .clk_i, .rst_ni, .shift_i(shift),
        .valid_i(c_valid[j-1]), .start_i(c_start[j-1]), .end_i(c_end[j-1]),
        .phys_i(c_phys[j-1]),
        .valid_o(c_valid[j]), .start_o(c_start[j]), .end_o(c_end[j]),
        .phys_o(c_phys[j])
      );
    end
  end

  assign hv = c_valid[ENTRIES-1];
  assign hs = c_start[ENTRIES-1];
  assign he = c_end[ENTRIES-1];
  assign hp = c_phys[ENTRIES-1];

  etc_eval #(.SW(SW)) u_eval (
    .valid_i(hv), .start_i(hs), .end_i(he), .phys_i(hp),
    .req_s_i(s_q), .req_e_i(e_q), .req_off_i(off_q),
    .ns_i(ns_q), .ne_i(ne_q), .np_i(np_q), .flags_o(fl)
  );

  // input decode and range end with saturation
  assign in_s     = SW'(s_axis_tdata[47:0]);
  assign in_len   = SW'(s_axis_tdata[95:48]);
  assign in_p     = SW'(s_axis_tdata[143:96]);
  assign len_zero = (in_len == '0);
  assign len_eff  = len_zero ? SW'(1) : in_len;
  assign sum      = {1'b0, in_s} + {1'b0, len_eff};

  assign k_last   = (k_q == IW'(ENTRIES - 1));
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !mv_q || m_axis_tready;
  assign shift    = (state_q == etc_pkg::ST_SCAN_A) || (state_q == etc_pkg::ST_SCAN_B) ||
                    (state_q == etc_pkg::ST_WRITE) || (state_q == etc_pkg::ST_LOOKUP) ||
                    (state_q == etc_pkg::ST_DROP);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      etc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          unique case (etc_pkg::etc_func_e'(s_axis_tuser))
            etc_pkg::FN_INSERT: state_d = (in_s == '1) ? etc_pkg::ST_IDLE
                                                       : etc_pkg::ST_SCAN_A;
            etc_pkg::FN_LOOKUP: state_d = etc_pkg::ST_LOOKUP;
            default:            state_d = etc_pkg::ST_DROP;
          endcase
        end
      end
      etc_pkg::ST_SCAN_A, etc_pkg::ST_LOOKUP, etc_pkg::ST_DROP: begin
        if (k_last) state_d = etc_pkg::ST_CHECK;
      end
      etc_pkg::ST_CHECK: begin
        if (func_q == etc_pkg::FN_INSERT && !sel_f_q && !cov_f_q) begin
          state_d = etc_pkg::ST_SCAN_B;
        end else begin
          state_d = etc_pkg::ST_IDLE;
        end
      end
      etc_pkg::ST_SCAN_B: begin
        if (k_last) state_d = etc_pkg::ST_MERGE;
      end
      etc_pkg::ST_MERGE: begin
        state_d = (!kill_f_q && !prv_f_q && !nxt_f_q && !free_f_q) ? etc_pkg::ST_IDLE
                                                                   : etc_pkg::ST_WRITE;
      end
      etc_pkg::ST_WRITE: begin
        if (k_last) state_d = etc_pkg::ST_IDLE;
      end
      default: state_d = etc_pkg::ST_IDLE;
    endcase
  end

  // ready only when idle and no result waits for the output register
  always_comb begin
    s_axis_tready = (state_q == etc_pkg::ST_IDLE) && !res_v_q;
  end

  // datapath updates per state
  always_comb begin
    k_d = shift ? (k_last ? '0 : k_q + IW'(1)) : k_q;
    func_d = func_q; s_d = s_q; e_d = e_q; off_d = off_q;
    ns_d = ns_q; ne_d = ne_q; np_d = np_q;
    sel_f_d = sel_f_q; sel_s_d = sel_s_q; sel_e_d = sel_e_q; sel_p_d = sel_p_q;
    cov_f_d = cov_f_q; cov_s_d = cov_s_q; cov_e_d = cov_e_q; cov_p_d = cov_p_q;
    kill_f_d = kill_f_q; free_f_d = free_f_q; wr_d = wr_q;
    prv_f_d = prv_f_q; prv_i_d = prv_i_q; prv_s_d = prv_s_q; prv_p_d = prv_p_q;
    nxt_f_d = nxt_f_q; nxt_i_d = nxt_i_q; nxt_e_d = nxt_e_q;
    cnt_d = cnt_q;
    res_v_d = res_v_q; res_st_d = res_st_q; res_hit_d = res_hit_q;
    res_s_d = res_s_q; res_e_d = res_e_q; res_p_d = res_p_q; res_rm_d = res_rm_q;
    t_valid = hv; t_start = hs; t_end = he; t_phys = hp;
    drop = 1'b0;

    unique case (state_q)
      etc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          func_d = etc_pkg::etc_func_e'(s_axis_tuser);
          s_d    = in_s;
          e_d    = sum[SW] ? '1 : sum[SW-1:0];
          off_d  = in_p - in_s;
          ns_d   = in_s;
          ne_d   = sum[SW] ? '1 : sum[SW-1:0];
          np_d   = in_p;
          sel_f_d = 1'b0; cov_f_d = 1'b0; kill_f_d = 1'b0; free_f_d = 1'b0;
          prv_f_d = 1'b0; nxt_f_d = 1'b0; wr_d = 1'b0; cnt_d = '0;
          res_st_d = etc_pkg::STS_OK; res_hit_d = 1'b0; res_rm_d = '0;
          res_s_d = '0; res_e_d = '0; res_p_d = '0;
          // empty range after saturation: refused at once
          if (etc_pkg::etc_func_e'(s_axis_tuser) == etc_pkg::FN_INSERT && in_s == '1) begin
            res_st_d = etc_pkg::STS_COVERED;
            res_v_d  = 1'b1;
          end
        end
      end
      etc_pkg::ST_SCAN_A: begin
        if (fl.overlap && fl.off_diff && (!sel_f_q || hs < sel_s_q)) begin
          sel_f_d = 1'b1; sel_s_d = hs; sel_e_d = he; sel_p_d = hp;
        end
        if (fl.covers && !cov_f_q) begin
          cov_f_d = 1'b1; cov_s_d = hs; cov_e_d = he; cov_p_d = hp;
        end
        if (fl.overlap) begin
          kill_f_d = 1'b1;
          if (hs < ns_q) begin
            ns_d = hs; np_d = hp;
          end
          if (he > ne_q) ne_d = he;
        end
        if (!hv) free_f_d = 1'b1;
      end
      etc_pkg::ST_LOOKUP: begin
        if (fl.end_gt_s && (!sel_f_q || hs < sel_s_q)) begin
          sel_f_d = 1'b1; sel_s_d = hs; sel_e_d = he; sel_p_d = hp;
        end
      end
      etc_pkg::ST_DROP: begin
        drop    = hv && (func_q == etc_pkg::FN_CLEAR || fl.end_gt_s);
        t_valid = hv && !drop;
        if (drop) cnt_d = cnt_q + CW'(1);
      end
      etc_pkg::ST_CHECK: begin
        res_v_d = !(func_q == etc_pkg::FN_INSERT && !sel_f_q && !cov_f_q);
        unique case (func_q)
          etc_pkg::FN_INSERT: begin
            if (sel_f_q) begin
              res_st_d = etc_pkg::STS_CONFLICT;
              res_s_d = sel_s_q; res_e_d = sel_e_q; res_p_d = sel_p_q;
            end else if (cov_f_q) begin
              res_st_d = etc_pkg::STS_COVERED;
              res_s_d = cov_s_q; res_e_d = cov_e_q; res_p_d = cov_p_q;
            end
          end
          etc_pkg::FN_LOOKUP: begin
            if (sel_f_q && sel_s_q < e_q) begin
              res_hit_d = 1'b1;
              res_s_d = sel_s_q; res_e_d = sel_e_q; res_p_d = sel_p_q;
            end
          end
          default: res_rm_d = RW'(cnt_q);
        endcase
      end
      etc_pkg::ST_SCAN_B: begin
        if (fl.prv_adj) begin
          prv_f_d = 1'b1; prv_i_d = k_q; prv_s_d = hs; prv_p_d = hp;
        end
        if (fl.nxt_adj) begin
          nxt_f_d = 1'b1; nxt_i_d = k_q; nxt_e_d = he;
        end
      end
      etc_pkg::ST_MERGE: begin
        if (prv_f_q) begin
          ns_d = prv_s_q; np_d = prv_p_q;
        end
        if (nxt_f_q) ne_d = nxt_e_q;
        if (!kill_f_q && !prv_f_q && !nxt_f_q && !free_f_q) begin
          res_st_d = etc_pkg::STS_FULL;
          res_v_d  = 1'b1;
        end
      end
      etc_pkg::ST_WRITE: begin
        drop    = fl.overlap || (prv_f_q && k_q == prv_i_q) || (nxt_f_q && k_q == nxt_i_q);
        t_valid = hv && !drop;
        // first free slot after removals takes the merged extent
        if (!t_valid && !wr_q) begin
          t_valid = 1'b1; t_start = ns_q; t_end = ne_q; t_phys = np_q;
          wr_d = 1'b1;
          res_st_d = etc_pkg::STS_OK;
          res_s_d = ns_q; res_e_d = ne_q; res_p_d = np_q;
        end
        if (k_last) res_v_d = 1'b1;
      end
      default: ;
    endcase

    // hand the finished result to the output register
    if (res_v_q && out_free) res_v_d = 1'b0;
  end

  // output register
  always_comb begin
    mv_d = mv_q;
    md_d = md_q;
    mu_d = mu_q;
    if (m_axis_tvalid && m_axis_tready) mv_d = 1'b0;
    if (res_v_q && out_free) begin
      mv_d = 1'b1;
      md_d = {3'b000, res_rm_q, FW'(res_p_q), FW'(res_e_q), FW'(res_s_q)};
      mu_d = {res_hit_q, res_st_q};
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tuser  = mu_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= etc_pkg::ST_IDLE;
      k_q     <= '0;
      res_v_q <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      res_v_q <= res_v_d;
      mv_q    <= mv_d;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    func_q <= func_d; s_q <= s_d; e_q <= e_d; off_q <= off_d;
    ns_q <= ns_d; ne_q <= ne_d; np_q <= np_d;
    sel_f_q <= sel_f_d; sel_s_q <= sel_s_d; sel_e_q <= sel_e_d; sel_p_q <= sel_p_d;
    cov_f_q <= cov_f_d; cov_s_q <= cov_s_d; cov_e_q <= cov_e_d; cov_p_q <= cov_p_d;
    kill_f_q <= kill_f_d; free_f_q <= free_f_d; wr_q <= wr_d;
    prv_f_q <= prv_f_d; prv_i_q <= prv_i_d; prv_s_q <= prv_s_d; prv_p_q <= prv_p_d;
    nxt_f_q <= nxt_f_d; nxt_i_q <= nxt_i_d; nxt_e_q <= nxt_e_d;
    cnt_q <= cnt_d;
    res_st_q <= res_st_d; res_hit_q <= res_hit_d;
    res_s_q <= res_s_d; res_e_q <= res_e_d; res_p_q <= res_p_d; res_rm_q <= res_rm_d;
    md_q <= md_d; mu_q <= mu_d;
  end

  // checks
  `ETC_ASSERT_NOW(a_idle_aligned, state_q == etc_pkg::ST_IDLE, k_q == '0,
                  "ring not aligned while idle")
  `ETC_ASSERT_NOW(a_hit_ok, m_axis_tvalid && m_axis_tuser[2],
                  m_axis_tuser[1:0] == etc_pkg::STS_OK, "hit with bad status")
  `ETC_ASSERT_NEXT(a_write_done, state_q == etc_pkg::ST_WRITE && k_last, wr_q,
                   "write turn ended without placing the extent")
  `ETC_ASSERT_NEXT(a_res_moves, res_v_q && out_free, m_axis_tvalid,
                   "result not moved to output register")

endmodule
